### design/satdf_pkg.sv
// ----------------------------------------------------------------------------
// satdf_pkg
// Shared types, widths and helpers of the set-associative tag directory.
// ----------------------------------------------------------------------------
package satdf_pkg;

  // fixed field widths of the access and result beats
  localparam int ADDR_W     = 32;
  localparam int SET_IDX_W  = 2;
  localparam int WAY_USED_W = 1;
  localparam int CNT_W      = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_LOOKUP
  } satdf_state_e;

  // controller to datapath
  typedef struct packed {
    logic clear_we;
    logic load;
    logic mod_step;
    logic commit;
  } satdf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic mod_done;
    logic out_free;
  } satdf_sts_t;

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

### design/satdf_if.sv
// ----------------------------------------------------------------------------
// satdf_if
// Valid/ready channels for access beats and result beats.
// ----------------------------------------------------------------------------
interface satdf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

interface satdf_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [1:0]  set_index;
  logic [0:0]  way_used;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  logic [31:0] access_total;

  modport source (
    output valid, output hit, output set_index, output way_used,
    output hit_total, output miss_total, output access_total,
    input ready
  );
  modport sink (
    input valid, input hit, input set_index, input way_used,
    input hit_total, input miss_total, input access_total,
    output ready
  );
endinterface

### design/satdf_ctrl.sv
// ----------------------------------------------------------------------------
// satdf_ctrl
// Sequencer: clear sweep, accept, set computation, lookup and commit.
// ----------------------------------------------------------------------------
module satdf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  satdf_pkg::satdf_sts_t sts_i,
  output satdf_pkg::satdf_cmd_t cmd_o
);
  import satdf_pkg::*;

  satdf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_we = 1'b1;
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_done) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // a lookup with the result slot busy keeps waiting
  a_lookup_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) && !sts_i.out_free |=> (state_q == ST_LOOKUP))
    else $error("lookup left while result slot busy");

  a_load_to_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_MOD))
    else $error("accepted access did not start set computation");

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.clear_we, cmd_o.load, cmd_o.mod_step, cmd_o.commit}))
    else $error("overlapping datapath commands");

endmodule

### design/satdf_dp.sv
// ----------------------------------------------------------------------------
// satdf_dp
// Datapath: block number, set index, directory memory, way compare,
// fill pointer update, counters and result register.
// ----------------------------------------------------------------------------
module satdf_dp #(
  parameter int SETS        = 4,
  parameter int WAYS        = 2,
  parameter int OFFSET_BITS = 1,
  parameter int ADDR_BITS   = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  satdf_pkg::satdf_cmd_t               cmd_i,
  output satdf_pkg::satdf_sts_t               sts_o,
  input  logic [satdf_pkg::ADDR_W-1:0]        address_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic                                hit_o,
  output logic [satdf_pkg::SET_IDX_W-1:0]     set_index_o,
  output logic [satdf_pkg::WAY_USED_W-1:0]    way_used_o,
  output logic [satdf_pkg::CNT_W-1:0]         hit_total_o,
  output logic [satdf_pkg::CNT_W-1:0]         miss_total_o,
  output logic [satdf_pkg::CNT_W-1:0]         access_total_o
);
  import satdf_pkg::*;

  localparam int AEFF    = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int BLK_W   = ((AEFF - OFFSET_BITS) > 0) ? (AEFF - OFFSET_BITS) : 1;
  localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAGS_W  = WAYS * BLK_W;
  localparam int ROW_W   = WAY_W + WAYS + TAGS_W;
  localparam bit IS_POW2 = ((SETS & (SETS - 1)) == 0);
  localparam logic [ADDR_W-1:0] AMASK =
    (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << AEFF) - 64'd1);

  // block number
  logic [ADDR_W-1:0] addr_m, blk_full;
  logic [BLK_W-1:0]  block_q;

  assign addr_m   = address_i & AMASK;
  assign blk_full = addr_m >> OFFSET_BITS;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) block_q <= blk_full[BLK_W-1:0];
  end

  // set index
  logic [SET_W-1:0] set_w;
  logic             mod_done;

  if (SETS == 1) begin : g_one_set
    assign set_w    = '0;
    assign mod_done = 1'b1;
  end else if (IS_POW2) begin : g_pow2
    logic [BLK_W+SET_W-1:0] blk_ext;
    logic [SET_W-1:0]       set_q;
    assign blk_ext = {{SET_W{1'b0}}, blk_full[BLK_W-1:0]};
    always_ff @(posedge clk_i) begin
      if (cmd_i.load) set_q <= blk_ext[SET_W-1:0];
    end
    assign set_w    = set_q;
    assign mod_done = 1'b1;
  end else begin : g_recip
    // quotient by reciprocal multiply, then remainder by multiply-subtract
    localparam int             PROD_W = 2 * BLK_W + 1;
    localparam logic [BLK_W:0] RECIP  =
      (BLK_W + 1)'(((64'd1 << (BLK_W + SET_W)) / 64'(SETS)) + 64'd1);
    logic [PROD_W-1:0] prod;
    logic [BLK_W-1:0]  back;
    logic [BLK_W-1:0]  quo_q;
    logic [SET_W-1:0]  rem_q;
    logic [1:0]        cnt_q;
    assign prod = {{(BLK_W + 1){1'b0}}, block_q} * {{BLK_W{1'b0}}, RECIP};
    assign back = quo_q * BLK_W'(SETS);
    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        cnt_q <= 2'd2;
      end else if (cmd_i.mod_step && (cnt_q != '0)) begin
        if (cnt_q == 2'd2) quo_q <= BLK_W'(prod >> (BLK_W + SET_W));
        else               rem_q <= SET_W'(block_q - back);
        cnt_q <= cnt_q - 2'd1;
      end
    end
    assign set_w    = rem_q;
    assign mod_done = (cnt_q == '0);
  end

  // clearing sweep index
  logic [SET_W-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_we) begin
      clr_q <= clr_q + SET_W'(1);
    end
  end

  // directory memory, one row per set: fill pointer, valid bits, tags
  logic [ROW_W-1:0] mem_q [SETS];
  logic [ROW_W-1:0] rd_q, row_upd, wdata;
  logic [SET_W-1:0] waddr;
  logic             we;

  assign we    = cmd_i.clear_we | cmd_i.commit;
  assign waddr = cmd_i.clear_we ? clr_q : set_w;
  assign wdata = cmd_i.clear_we ? '0 : row_upd;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (cmd_i.mod_step) rd_q <= mem_q[set_w];
  end

  // way compare and replacement
  logic [WAYS-1:0]  vld, match;
  logic [WAY_W-1:0] ptr, ptr_nxt, hit_way, way_sel;
  logic             hit;

  assign vld     = rd_q[TAGS_W +: WAYS];
  assign ptr     = rd_q[ROW_W-1 -: WAY_W];
  assign ptr_nxt = (ptr == WAY_W'(WAYS - 1)) ? '0 : ptr + WAY_W'(1);
  assign hit     = |match;
  assign way_sel = hit ? hit_way : ptr;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = vld[w] && (rd_q[w*BLK_W +: BLK_W] == block_q);
    end
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WAY_W'(w);
    end
  end

  always_comb begin
    row_upd = rd_q;
    if (!hit) begin
      for (int w = 0; w < WAYS; w++) begin
        if (ptr == WAY_W'(w)) begin
          row_upd[w*BLK_W +: BLK_W] = block_q;
          row_upd[TAGS_W + w]       = 1'b1;
        end
      end
      row_upd[ROW_W-1 -: WAY_W] = ptr_nxt;
    end
  end

  // counters
  logic [CNT_W-1:0] hit_q, miss_q, acc_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= '0;
      miss_q <= '0;
      acc_q  <= '0;
    end else if (cmd_i.commit) begin
      acc_q <= sat_inc(acc_q);
      if (hit) hit_q  <= sat_inc(hit_q);
      else     miss_q <= sat_inc(miss_q);
    end
  end

  // result register
  logic                  out_valid_q, hit_out_q;
  logic [SET_IDX_W-1:0]  set_out_q;
  logic [WAY_USED_W-1:0] way_out_q;
  logic [SET_W+1:0]      set_ext;
  logic [WAY_W:0]        way_ext;

  assign set_ext = {2'b00, set_w};
  assign way_ext = {1'b0, way_sel};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_out_q <= hit;
      set_out_q <= set_ext[SET_IDX_W-1:0];
      way_out_q <= way_ext[WAY_USED_W-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_out_q;
  assign set_index_o    = set_out_q;
  assign way_used_o     = way_out_q;
  assign hit_total_o    = hit_q;
  assign miss_total_o   = miss_q;
  assign access_total_o = acc_q;

  assign sts_o.clear_last = (clr_q == SET_W'(SETS - 1));
  assign sts_o.mod_done   = mod_done;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // a block lives in at most one way of its set
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> $onehot0(match))
    else $error("block present in more than one way");

  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_q != CNT_MAX) |-> ({1'b0, acc_q} == ({1'b0, hit_q} + {1'b0, miss_q})))
    else $error("access count differs from hits plus misses");

  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q && (acc_q == sat_inc($past(acc_q))))
    else $error("commit did not present a result");

endmodule

### design/set_assoc_tag_directory_fifo.sv
// ----------------------------------------------------------------------------
// set_assoc_tag_directory_fifo
// Tag directory of a set-associative cache with round-robin replacement.
// ----------------------------------------------------------------------------
// Each access beat carries a binary word address. The low OFFSET_BITS are
// dropped to form the block number (address bits at and above ADDR_BITS are
// ignored), the set is the block number modulo SETS, and the block is
// compared in parallel against all valid ways of that set. A hit leaves the
// directory untouched; a miss writes the block into the way named by the
// set's fill pointer and advances that pointer round-robin. Each access gives
// one result beat with the hit flag, the set, the way hit or filled, and
// saturating hit, miss and access totals. Timing: after reset the directory
// is swept clear one set per cycle, and no access is taken during the sweep.
// An access then runs through accept, directory row read, and compare and
// commit when SETS is a power of two; otherwise the set remainder is first
// formed by a reciprocal multiply and a multiply-subtract, each registered,
// ahead of the row read. The directory memory, one row per set, is read in
// each set computation step and written once per access. A finished result
// sits in an output register, so the next access is accepted while it waits;
// a second result then waits in the commit step until the first beat is taken.
// ----------------------------------------------------------------------------
module set_assoc_tag_directory_fifo #(
  parameter int SETS        = 4,
  parameter int WAYS        = 2,
  parameter int OFFSET_BITS = 1,
  parameter int ADDR_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  satdf_in_if.sink    in_i,
  satdf_out_if.source out_o
);
  import satdf_pkg::*;

  // command and status between sequencer and datapath
  satdf_cmd_t cmd;
  satdf_sts_t sts;
  logic       in_ready;

  satdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  satdf_dp #(
    .SETS        (SETS),
    .WAYS        (WAYS),
    .OFFSET_BITS (OFFSET_BITS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .address_i      (in_i.address),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .hit_o          (out_o.hit),
    .set_index_o    (out_o.set_index),
    .way_used_o     (out_o.way_used),
    .hit_total_o    (out_o.hit_total),
    .miss_total_o   (out_o.miss_total),
    .access_total_o (out_o.access_total)
  );

  // input beat is taken only when the sequencer sits idle
  assign in_i.ready = in_ready;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-way tag directory with round-robin fill.
// ----------------------------------------------------------------------------
// Access beats come from a short hand-picked sequence and then from a rotating
// pool of block numbers. The pool is mixed with same-set neighbors and fully
// random addresses, so hits, cold misses and evictions all occur in every set.
// A scoreboard keeps its own copy of the directory, the fill pointers and the
// counters, and checks every result beat in order, field by field. Both
// channels idle in random bursts. One long result hold-off backs the block up,
// and one drain pause empties it.
// ----------------------------------------------------------------------------
module tb_top;
  import satdf_pkg::*;

  // geometry of the block as instantiated (its default parameters)
  localparam int NUM_SETS  = 4;
  localparam int NUM_WAYS  = 2;
  localparam int BLOCK_OFS = 1;

  localparam int CLK_HALF    = 5;
  localparam int RST_CYCLES  = 7;
  localparam int LONG_HOLD   = 300;    // cycles the result side refuses beats
  localparam int DRAIN_WAIT  = 20;     // quiet cycles after the last result
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_SEGS      = 11;     // random part, in segments
  localparam int SEG_ITEMS   = 100;
  localparam int POOL_SIZE   = 10;

  typedef struct packed {
    logic                  hit;
    logic [SET_IDX_W-1:0]  set_index;
    logic [WAY_USED_W-1:0] way_used;
    logic [CNT_W-1:0]      hit_total;
    logic [CNT_W-1:0]      miss_total;
    logic [CNT_W-1:0]      access_total;
  } lookup_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: mirrors the directory and queues the expected result beats
  // --------------------------------------------------------------------------
  class lookup_scoreboard;
    bit [ADDR_W-1:0]  tag_row [NUM_SETS][NUM_WAYS];
    bit               line_valid [NUM_SETS][NUM_WAYS];
    int               fill_way [NUM_SETS];
    bit [CNT_W-1:0]   hits;
    bit [CNT_W-1:0]   misses;
    bit [CNT_W-1:0]   accesses;
    lookup_result_t   expected_q [$];
    int               mismatches;
    int               evictions;

    function bit [CNT_W-1:0] bump(bit [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1;
    endfunction

    // an access beat was taken: look it up and update the mirror
    function void note_access(logic [ADDR_W-1:0] addr);
      bit [ADDR_W-1:0] blk;
      int              set_no;
      int              way_no;
      bit              found;
      lookup_result_t  r;
      blk    = addr >> BLOCK_OFS;
      set_no = blk % NUM_SETS;
      found  = 1'b0;
      way_no = 0;
      // descending scan so the lowest matching way wins
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
        if (line_valid[set_no][w] && tag_row[set_no][w] == blk) begin
          found  = 1'b1;
          way_no = w;
        end
      end
      accesses = bump(accesses);
      if (found) begin
        hits = bump(hits);
      end else begin
        misses = bump(misses);
        way_no = fill_way[set_no];
        if (line_valid[set_no][way_no]) evictions++;
        tag_row[set_no][way_no]    = blk;
        line_valid[set_no][way_no] = 1'b1;
        fill_way[set_no]           = (way_no + 1) % NUM_WAYS;
      end
      r.hit          = found;
      r.set_index    = SET_IDX_W'(set_no);
      r.way_used     = WAY_USED_W'(way_no);
      r.hit_total    = hits;
      r.miss_total   = misses;
      r.access_total = accesses;
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string what, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
      mismatches++;
    endtask

    task check_result(lookup_result_t got);
      lookup_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat, access_total", '0, got.access_total);
        return;
      end
      want = expected_q.pop_front();
      if (got.hit !== want.hit)
        report_mismatch("hit", CNT_W'(want.hit), CNT_W'(got.hit));
      if (got.set_index !== want.set_index)
        report_mismatch("set_index", CNT_W'(want.set_index), CNT_W'(got.set_index));
      if (got.way_used !== want.way_used)
        report_mismatch("way_used", CNT_W'(want.way_used), CNT_W'(got.way_used));
      if (got.hit_total !== want.hit_total)
        report_mismatch("hit_total", want.hit_total, got.hit_total);
      if (got.miss_total !== want.miss_total)
        report_mismatch("miss_total", want.miss_total, got.miss_total);
      if (got.access_total !== want.access_total)
        report_mismatch("access_total", want.access_total, got.access_total);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  satdf_in_if  acc_if ();
  satdf_out_if res_if ();

  set_assoc_tag_directory_fifo dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (acc_if),
    .out_o  (res_if)
  );

  lookup_scoreboard dir_sb = new();

  bit               idle_on;     // random idle bursts allowed on both sides
  bit               hold_go;     // asks the hold timer for the long hold-off
  bit               rx_hold_on;  // result side held off by the hold timer
  int               cycle_count;
  logic [ADDR_W-1:0] block_pool [POOL_SIZE];

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------
  // offer one access beat and hold it until taken; an idle burst may follow
  task automatic send_access(input logic [ADDR_W-1:0] addr);
    acc_if.valid   <= 1'b1;
    acc_if.address <= addr;
    do @(posedge clk); while (acc_if.ready !== 1'b1);
    dir_sb.note_access(addr);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      acc_if.valid   <= 1'b0;
      acc_if.address <= $urandom;  // junk while idle, must be ignored
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // mostly pool blocks (hits), some same-set neighbors (conflict misses)
  // and some fully random addresses (cold misses, all address bits)
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] blk;
    int                roll;
    roll = $urandom_range(0, 99);
    if (roll >= 85) return $urandom;
    blk = block_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (roll >= 70) blk = blk + NUM_SETS * $urandom_range(1, 3);
    return (blk << BLOCK_OFS) | $urandom_range(0, (1 << BLOCK_OFS) - 1);
  endfunction

  // --------------------------------------------------------------------------
  // receiver side: checks every taken result beat, then decides ready
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int             stall_left;
    lookup_result_t got;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        got.hit          = res_if.hit;
        got.set_index    = res_if.set_index;
        got.way_used     = res_if.way_used;
        got.hit_total    = res_if.hit_total;
        got.miss_total   = res_if.miss_total;
        got.access_total = res_if.access_total;
        dir_sb.check_result(got);
      end
      if (rx_hold_on) begin
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // long hold-off of the result side, counted here while the sender keeps going
  initial begin : rx_hold_timer
    wait (hold_go);
    @(posedge clk);
    rx_hold_on <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_hold_on <= 1'b0;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still due", cycle_count,
             dir_sb.expected_q.size());
    $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [ADDR_W-1:0] directed_addrs [$];
    // set 0 fill, hit on both ways (offset bit ignored), eviction of each way,
    // both ends of the address range, a hit on way 1, then every set and
    // alternating bit patterns
    directed_addrs = '{
      32'h0000_0000, 32'h0000_0001, 32'h0000_0008, 32'h0000_0009,
      32'h0000_0010, 32'h0000_0000, 32'h0000_0011, 32'hFFFF_FFFF,
      32'hFFFF_FFFE, 32'h7FFF_FFFE, 32'h8000_0000, 32'h0000_0002,
      32'h0000_0004, 32'h0000_0006, 32'hAAAA_AAAA, 32'h5555_5555,
      32'hAAAA_AAAB, 32'h5555_5554, 32'h0000_0003, 32'hFFFF_FFFF,
      32'h7FFF_FFFF
    };
    rst_n          <= 1'b0;
    acc_if.valid   <= 1'b0;
    acc_if.address <= '0;
    idle_on        <= 1'b1;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // the block sweeps its directory after reset; ready stays low meanwhile
    foreach (directed_addrs[i]) send_access(directed_addrs[i]);

    // sender pause until every result is back
    acc_if.valid <= 1'b0;
    while (dir_sb.expected_q.size() != 0) @(posedge clk);

    // random part; the first segment runs under the long hold-off, every
    // third segment and the final one run with no idling at all
    for (int seg = 0; seg < N_SEGS; seg++) begin
      foreach (block_pool[i]) block_pool[i] = $urandom >> BLOCK_OFS;
      if (seg == 0) hold_go <= 1'b1;
      idle_on <= (seg % 3 != 2) && (seg != N_SEGS - 1);
      repeat (SEG_ITEMS) send_access(pick_address());
    end

    acc_if.valid <= 1'b0;
    while (dir_sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d accesses: %0d hits, %0d misses, %0d evictions", dir_sb.accesses,
             dir_sb.hits, dir_sb.misses, dir_sb.evictions);
    $display("with idle bursts on both sides, a %0d-cycle result hold-off and a drain pause",
             LONG_HOLD);
    if (dir_sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
